/* sv/thl_pkg.sv */
// Shared types and codes for the two-wire handshake link.
// Holds the word structs for both channels and the command and status codes.
// No dependencies.
`timescale 1ns / 1ps

package thl_pkg;

  // Width of one byte on the link and of the locally held byte registers.
  localparam int unsigned BYTE_W = 8;

  // Default number of bits moved per transfer.
  localparam int unsigned BITS_PER_WORD_DEF = 8;

  // Value returned in place of a byte after a transmission error.
  localparam logic [BYTE_W-1:0] ERROR_BYTE = 8'hFF;

  // Command codes carried in the input word.
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_RECEIVE = 2'd2,
    CMD_SPY     = 2'd3
  } cmd_t;

  // Completion status codes carried in the result word.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_ERROR   = 2'd2,
    STAT_UNUSED  = 2'd3
  } status_t;

  // Input word: command, byte to send and the sampled line levels.
  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] send_byte;
    logic              red_level;
    logic              white_level;
  } item_t;

  // Result word: line drives, progress flags, status, decoded byte and partner flag.
  typedef struct packed {
    logic              pull_red;
    logic              pull_white;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [BYTE_W-1:0] received_byte;
    logic              partner_active;
  } result_t;

endpackage

/* sv/two_wire_handshake_link_top.sv */
// Two-wire (red/white) open-drain byte link controller, one line sample per word.
// Depends on thl_pkg for the word structs, command codes and status codes.
// Sends LSB first, receives or spies, and reports one result word per input word.
//
//   Channel   Direction  Handshake                 Payload
//   item      in         item_valid / item_ready   item (thl_pkg::item_t)
//   result    out        result_valid/result_ready result (thl_pkg::result_t)
//
// Each input word is processed in the cycle it is accepted; its result word is
// held in the result register from the next cycle on.
// One word is accepted per cycle while the result side takes words each cycle.
// The result register is the only buffer: when it is full and not taken,
// item_ready drops and the link state holds still.
// rst is synchronous and active high; it returns the controller to idle and
// empties the result register.
`timescale 1ns / 1ps

module two_wire_handshake_link_top #(
  parameter int unsigned BITS_PER_WORD = thl_pkg::BITS_PER_WORD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  thl_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output thl_pkg::result_t result
);

  import thl_pkg::*;

  // Counter wide enough to hold BITS_PER_WORD itself.
  localparam int unsigned CNT_W = $clog2(BITS_PER_WORD + 1);
  localparam int unsigned IDX_W = $clog2(BYTE_W);

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_SEND_DRIVE   = 3'd1,
    PH_WAIT_RELEASE = 3'd2,
    PH_RX_WAIT_BIT  = 3'd3,
    PH_RX_HOLD_ONE  = 3'd4,
    PH_RX_HOLD_ZERO = 3'd5,
    PH_ERR_WAIT     = 3'd6
  } phase_t;

  phase_t            phase, phase_next;
  cmd_t              operation, operation_next;
  logic [CNT_W-1:0]  bit_count, bit_count_next;
  logic [BYTE_W-1:0] shift_data, shift_data_next;
  logic [BYTE_W-1:0] outgoing_byte, outgoing_byte_next;
  logic              error_seen, error_seen_next;
  result_t           result_next;

  logic              accept;
  logic              lines_idle;
  logic [CNT_W-1:0]  count_inc;
  logic              cur_in_byte;
  logic              cur_send_bit;
  logic              next_in_byte;
  logic              next_send_bit;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  next_idx;
  logic              done;
  status_t           status;
  logic [BYTE_W-1:0] rbyte;

  // A new word enters whenever the result register is empty or being emptied.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign lines_idle = item.red_level && item.white_level;
  assign count_inc  = bit_count + CNT_W'(1);

  // Bit to send under the present count; bits past the byte are sent as zero.
  assign cur_idx      = IDX_W'(bit_count);
  assign cur_in_byte  = 32'(bit_count) < 32'(BYTE_W);
  assign cur_send_bit = cur_in_byte && outgoing_byte[cur_idx];

  // Next-state logic for one line sample.
  always_comb begin
    phase_next         = phase;
    operation_next     = operation;
    bit_count_next     = bit_count;
    shift_data_next    = shift_data;
    outgoing_byte_next = outgoing_byte;
    error_seen_next    = error_seen;
    done               = 1'b0;
    status             = STAT_OK;
    rbyte              = '0;

    unique case (phase)
      PH_SEND_DRIVE: begin
        if (cur_send_bit ? !item.white_level : !item.red_level) begin
          phase_next = PH_WAIT_RELEASE;
        end
      end
      PH_WAIT_RELEASE: begin
        if (lines_idle) begin
          bit_count_next = count_inc;
          if (32'(count_inc) >= 32'(BITS_PER_WORD)) begin
            done       = 1'b1;
            rbyte      = (operation == CMD_SEND) ? '0 : shift_data;
            phase_next = PH_IDLE;
          end else begin
            phase_next = (operation == CMD_SEND) ? PH_SEND_DRIVE : PH_RX_WAIT_BIT;
          end
        end
      end
      PH_RX_WAIT_BIT: begin
        if (!item.red_level && !item.white_level) begin
          error_seen_next = 1'b1;
          phase_next      = PH_ERR_WAIT;
        end else if (!item.red_level) begin
          if (cur_in_byte) begin
            shift_data_next[cur_idx] = 1'b1;
          end
          phase_next = PH_RX_HOLD_ONE;
        end else if (!item.white_level) begin
          phase_next = PH_RX_HOLD_ZERO;
        end
      end
      PH_RX_HOLD_ONE: begin
        if (item.red_level) begin
          phase_next = PH_WAIT_RELEASE;
        end
      end
      PH_RX_HOLD_ZERO: begin
        if (item.white_level) begin
          phase_next = PH_WAIT_RELEASE;
        end
      end
      PH_ERR_WAIT: begin
        if (lines_idle) begin
          done       = 1'b1;
          status     = STAT_ERROR;
          rbyte      = ERROR_BYTE;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // Idle, and the unused phase code behaves the same way.
        phase_next = PH_IDLE;
        if (cmd_t'(item.command) == CMD_SEND) begin
          if (!lines_idle) begin
            done   = 1'b1;
            status = STAT_REFUSED;
          end else begin
            operation_next     = CMD_SEND;
            outgoing_byte_next = item.send_byte;
            bit_count_next     = '0;
            error_seen_next    = 1'b0;
            phase_next         = PH_SEND_DRIVE;
          end
        end else if (cmd_t'(item.command) == CMD_RECEIVE ||
                     cmd_t'(item.command) == CMD_SPY) begin
          operation_next  = cmd_t'(item.command);
          shift_data_next = '0;
          bit_count_next  = '0;
          error_seen_next = 1'b0;
          phase_next      = PH_RX_WAIT_BIT;
        end
      end
    endcase
  end

  // Line drives follow the state reached after this sample.
  assign next_idx      = IDX_W'(bit_count_next);
  assign next_in_byte  = 32'(bit_count_next) < 32'(BYTE_W);
  assign next_send_bit = next_in_byte && outgoing_byte_next[next_idx];

  always_comb begin
    result_next                = '0;
    result_next.busy_res       = (phase_next != PH_IDLE);
    result_next.done_res       = done;
    result_next.status         = status;
    result_next.received_byte  = rbyte;
    result_next.partner_active = !lines_idle;
    if (phase_next == PH_SEND_DRIVE) begin
      result_next.pull_red   = next_send_bit;
      result_next.pull_white = !next_send_bit;
    end else if (operation_next == CMD_RECEIVE) begin
      // Acknowledge by pulling the line opposite to the one the sender pulls.
      result_next.pull_white = (phase_next == PH_RX_HOLD_ONE);
      result_next.pull_red   = (phase_next == PH_RX_HOLD_ZERO);
    end
  end

  // Link state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= CMD_NONE;
      bit_count     <= '0;
      shift_data    <= '0;
      outgoing_byte <= '0;
      error_seen    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        operation     <= operation_next;
        bit_count     <= bit_count_next;
        shift_data    <= shift_data_next;
        outgoing_byte <= outgoing_byte_next;
        error_seen    <= error_seen_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid  <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by result_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // An accepted word always leaves a result waiting in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted word produced no result");

  // The controller never pulls both lines at once.
  a_no_double_pull: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.pull_red && result.pull_white))
    else $error("both lines driven low");

  // A non-ok status only appears on a completion word.
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != STAT_OK) |-> result.done_res)
    else $error("status reported without completion");

  // Spying never drives the lines.
  a_spy_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid && (operation == CMD_SPY) |-> !result.pull_red && !result.pull_white)
    else $error("line driven while spying");

  // The error wait phase is only entered with the error flag set.
  a_error_path: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR_WAIT) |-> error_seen)
    else $error("error wait without error flag");

endmodule

/* verif/two_wire_handshake_link_top_tb.sv */
// Self-checking testbench for the two-wire handshake link controller.
// Depends on thl_pkg and two_wire_handshake_link_top; an internal scoreboard
// tracks the link state and checks every result word; partner_word plays the line partner.
`timescale 1ns / 1ps

module two_wire_handshake_link_top_tb;
  import thl_pkg::*;

  localparam int unsigned WORD_BITS = 8;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned STALL_LIMIT = 1500;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AT_RESULT = 400;

  // Progress of the link as the scoreboard sees it.
  typedef enum logic [2:0] {
    LP_IDLE,
    LP_SEND_DRIVE,
    LP_WAIT_RELEASE,
    LP_RX_WAIT_BIT,
    LP_RX_HOLD_ONE,
    LP_RX_HOLD_ZERO,
    LP_ERR_WAIT
  } link_phase_e;

  // Tracks the link state word by word and holds the result words still due.
  class link_scoreboard;
    link_phase_e phase;
    cmd_t        op;
    int unsigned bit_cnt;
    logic [7:0]  out_byte;
    logic [7:0]  in_shift;
    result_t     due_q[$];
    int unsigned failures;

    function new();
      phase = LP_IDLE;
      op = CMD_NONE;
      bit_cnt = 0;
      out_byte = '0;
      in_shift = '0;
      failures = 0;
    endfunction

    // Bit on the wire during a send; bits past the byte go out as zero.
    function logic sending_bit();
      return (bit_cnt < 8) ? out_byte[bit_cnt[2:0]] : 1'b0;
    endfunction

    // Moves the link one sample forward and returns the result word it gives.
    function result_t advance_link(item_t w);
      result_t r;
      logic    lines_idle;
      r = '0;
      lines_idle = w.red_level && w.white_level;
      case (phase)
        LP_IDLE: begin
          if (w.command == CMD_SEND) begin
            if (!lines_idle) begin
              r.done_res = 1'b1;
              r.status = STAT_REFUSED;
            end else begin
              op = CMD_SEND;
              out_byte = w.send_byte;
              bit_cnt = 0;
              phase = LP_SEND_DRIVE;
            end
          end else if (w.command == CMD_RECEIVE || w.command == CMD_SPY) begin
            op = cmd_t'(w.command);
            in_shift = '0;
            bit_cnt = 0;
            phase = LP_RX_WAIT_BIT;
          end
        end
        LP_SEND_DRIVE: begin
          if (sending_bit() ? !w.white_level : !w.red_level) phase = LP_WAIT_RELEASE;
        end
        LP_WAIT_RELEASE: begin
          if (lines_idle) begin
            bit_cnt++;
            if (bit_cnt >= WORD_BITS) begin
              r.done_res = 1'b1;
              r.status = STAT_OK;
              r.received_byte = (op == CMD_SEND) ? 8'h00 : in_shift;
              phase = LP_IDLE;
            end else begin
              phase = (op == CMD_SEND) ? LP_SEND_DRIVE : LP_RX_WAIT_BIT;
            end
          end
        end
        LP_RX_WAIT_BIT: begin
          if (!w.red_level && !w.white_level) begin
            phase = LP_ERR_WAIT;
          end else if (!w.red_level) begin
            if (bit_cnt < 8) in_shift[bit_cnt[2:0]] = 1'b1;
            phase = LP_RX_HOLD_ONE;
          end else if (!w.white_level) begin
            phase = LP_RX_HOLD_ZERO;
          end
        end
        LP_RX_HOLD_ONE: begin
          if (w.red_level) phase = LP_WAIT_RELEASE;
        end
        LP_RX_HOLD_ZERO: begin
          if (w.white_level) phase = LP_WAIT_RELEASE;
        end
        default: begin
          if (lines_idle) begin
            r.done_res = 1'b1;
            r.status = STAT_ERROR;
            r.received_byte = ERROR_BYTE;
            phase = LP_IDLE;
          end
        end
      endcase

      // Line drives follow the phase just entered; spy mode never drives.
      if (phase == LP_SEND_DRIVE) begin
        r.pull_red = sending_bit();
        r.pull_white = !sending_bit();
      end else if (op == CMD_RECEIVE) begin
        r.pull_white = (phase == LP_RX_HOLD_ONE);
        r.pull_red = (phase == LP_RX_HOLD_ZERO);
      end
      r.busy_res = (phase != LP_IDLE);
      r.partner_active = !lines_idle;
      return r;
    endfunction

    function void note_item(item_t w);
      due_q.push_back(advance_link(w));
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t r);
      result_t want;
      if (due_q.size() == 0) begin
        $error("result word arrived with nothing due");
        failures++;
        return;
      end
      want = due_q.pop_front();
      cmp_field("pull_red", 32'(want.pull_red), 32'(r.pull_red));
      cmp_field("pull_white", 32'(want.pull_white), 32'(r.pull_white));
      cmp_field("busy_res", 32'(want.busy_res), 32'(r.busy_res));
      cmp_field("done_res", 32'(want.done_res), 32'(r.done_res));
      cmp_field("status", 32'(want.status), 32'(r.status));
      cmp_field("received_byte", 32'(want.received_byte), 32'(r.received_byte));
      cmp_field("partner_active", 32'(want.partner_active), 32'(r.partner_active));
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  link_scoreboard sb = new();
  bit          hold_active;
  bit          sender_calm;
  int unsigned sent_count;
  int unsigned taken_count;
  int unsigned quiet_cycles;

  two_wire_handshake_link_top #(
    .BITS_PER_WORD(WORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #4 clk = ~clk;

  function automatic item_t mk(cmd_t c, logic [7:0] b, logic red, logic white);
    item_t w;
    w.command = c;
    w.send_byte = b;
    w.red_level = red;
    w.white_level = white;
    return w;
  endfunction

  // Plays the far end of the link: mostly well-formed line activity for the
  // current phase, with some words of pure noise mixed in.
  function automatic item_t partner_word();
    item_t       w;
    int unsigned roll;
    int unsigned pick;
    logic        bit_now;
    w.command = 2'($urandom_range(0, 3));
    w.send_byte = 8'($urandom);
    w.red_level = 1'b1;
    w.white_level = 1'b1;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 63);
    bit_now = sb.sending_bit();
    if (roll < 10) begin
      w.red_level = 1'($urandom);
      w.white_level = 1'($urandom);
      return w;
    end
    case (sb.phase)
      LP_IDLE: begin
        if (roll < 20) w.command = CMD_NONE;
        else if (roll < 50) w.command = CMD_SEND;
        else if (roll < 75) w.command = CMD_RECEIVE;
        else w.command = CMD_SPY;
        if (pick < 6) {w.red_level, w.white_level} = 2'($urandom_range(0, 2));
      end
      LP_SEND_DRIVE: begin
        // The partner acknowledges on the opposite line about one time in three.
        if (pick < 21) begin
          if (bit_now) begin
            w.white_level = 1'b0;
            w.red_level = 1'($urandom);
          end else begin
            w.red_level = 1'b0;
            w.white_level = 1'($urandom);
          end
        end else if (bit_now) begin
          w.red_level = 1'($urandom);
        end else begin
          w.white_level = 1'($urandom);
        end
      end
      LP_WAIT_RELEASE, LP_ERR_WAIT: begin
        if (pick < 32) {w.red_level, w.white_level} = 2'($urandom_range(0, 2));
      end
      LP_RX_WAIT_BIT: begin
        // Rarely both lines drop together, which is a transmission error.
        if (pick == 0) begin
          w.red_level = 1'b0;
          w.white_level = 1'b0;
        end else if (pick <= 20) begin
          w.red_level = 1'b0;
        end else if (pick <= 40) begin
          w.white_level = 1'b0;
        end
      end
      default: begin
        w.red_level = 1'($urandom);
        w.white_level = 1'($urandom);
      end
    endcase
    return w;
  endfunction

  // Offers one input word after a random gap and notes it once taken.
  task automatic offer_word(input item_t w);
    int unsigned gap;
    if (sent_count % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = (sender_calm || hold_active) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    sb.note_item(w);
    sent_count++;
  endtask

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin : result_taker
    int unsigned gap;
    bit          calm;
    bit          hold_done;
    calm = 1'b0;
    hold_done = 1'b0;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken_count % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 17);
      if (!hold_done && taken_count == HOLD_AT_RESULT) begin
        gap = HOLD_CYCLES;
        hold_done = 1'b1;
        hold_active = 1'b1;
      end
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hold_active = 1'b0;
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
      taken_count++;
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("two_wire_handshake_link_top_tb failed");
        $finish;
      end
    end
  end

  // Reset, directed words, then random partner traffic and the final verdict.
  initial begin : word_source
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sends refused on busy lines, then a receive that hits an error.
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_SEND, 8'hFF, 1'b0, 1'b1));
    offer_word(mk(CMD_SEND, 8'h00, 1'b1, 1'b0));
    offer_word(mk(CMD_SEND, 8'h5A, 1'b0, 1'b0));
    offer_word(mk(CMD_RECEIVE, 8'hFF, 1'b1, 1'b1));
    offer_word(mk(CMD_SEND, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_SPY, 8'h00, 1'b0, 1'b0));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    // Spy on a one and a zero, then an error in the middle of the byte.
    offer_word(mk(CMD_SPY, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b1));
    offer_word(mk(CMD_RECEIVE, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b0));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b0));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b0));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    // Start of a send: the first two bits driven and each acknowledged.
    offer_word(mk(CMD_SEND, 8'hA5, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b0));
    offer_word(mk(CMD_NONE, 8'h00, 1'b1, 1'b1));
    offer_word(mk(CMD_NONE, 8'h00, 1'b0, 1'b0));

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) offer_word(partner_word());
    item_valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("two_wire_handshake_link_top_tb passed");
    end else begin
      $display("two_wire_handshake_link_top_tb failed");
    end
    $finish;
  end

endmodule
